@@ rtl/kfn_pkg.sv @@
// ----------------------------------------------------------------------------
// kfn_pkg
// Shared types, register indexes, sequencer states and channel group
// constants for the multichannel Kalman normalizer.
// ----------------------------------------------------------------------------
package kfn_pkg;

  localparam int CH_W      = 3;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_CH    = 8;

  typedef logic        [CH_W-1:0]      chan_t;
  typedef logic signed [DATA_W-1:0]    fix_t;
  typedef logic        [DATA_W-1:0]    word_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t REG_PROCESS_NOISE     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MEASUREMENT_NOISE = cfg_idx_t'(1);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL_EST,
    S_MUL_ERR,
    S_NORM,
    S_DONE
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // channel groups
  typedef enum logic [1:0] {
    GRP_TEMP,
    GRP_ACCEL,
    GRP_GYRO,
    GRP_LIGHT
  } group_t;

  localparam chan_t CH_TEMP       = chan_t'(0);
  localparam chan_t CH_ACCEL_LAST = chan_t'(3);
  localparam chan_t CH_GYRO_LAST  = chan_t'(6);

  // normalization: (v + offset) * 1000 / divisor, reduced to a small
  // multiplier and a power-of-two shift
  localparam int NORM_K_W          = 10;
  localparam int NORM_K_TEMP       = 1000;
  localparam int NORM_K_ACCEL      = 125;
  localparam int NORM_K_GYRO       = 2;
  localparam int NORM_K_LIGHT      = 125;
  localparam int LIGHT_EXTRA_SHIFT = 7;
  localparam int ACCEL_OFFSET      = 4;
  localparam int GYRO_OFFSET       = 250;

  function automatic group_t group_of(input chan_t c);
    group_t g;
    priority if (c == CH_TEMP) begin
      g = GRP_TEMP;
    end else if (c <= CH_ACCEL_LAST) begin
      g = GRP_ACCEL;
    end else if (c <= CH_GYRO_LAST) begin
      g = GRP_GYRO;
    end else begin
      g = GRP_LIGHT;
    end
    return g;
  endfunction

endpackage

@@ rtl/kfn_if.sv @@
// ----------------------------------------------------------------------------
// kfn channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------

// sample request channel
interface kfn_req_if;
  logic            valid;
  logic            ready;
  kfn_pkg::chan_t  channel;
  kfn_pkg::fix_t   sample;

  modport source(output valid, output channel, output sample, input ready);
  modport sink(input valid, input channel, input sample, output ready);
endinterface

// result channel
interface kfn_res_if;
  logic            valid;
  logic            ready;
  kfn_pkg::chan_t  channel_out;
  kfn_pkg::fix_t   filtered;
  kfn_pkg::fix_t   normalized;

  modport source(output valid, output channel_out, output filtered,
                 output normalized, input ready);
  modport sink(input valid, input channel_out, input filtered,
               input normalized, output ready);
endinterface

// register write channel
interface kfn_cfg_if;
  logic              valid;
  logic              ready;
  kfn_pkg::cfg_idx_t index;
  kfn_pkg::word_t    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/multichannel_kalman_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_kalman_normalizer_unit
// Eight-channel scalar Kalman filter with per-group normalization. Each
// sample request updates its channel's estimate and error covariance and
// returns the new estimate plus the estimate offset and scaled for the
// channel group. One request is in work at a time; it passes through the
// bit-serial gain divider and then the shared shift-add multiplier, which
// makes three passes (estimate update, error update, normalization). The
// finished result sits in an output register, so the next request is taken
// while it waits. Register writes are taken in any cycle outside reset.
// ----------------------------------------------------------------------------
module multichannel_kalman_normalizer_unit #(
  parameter int FRACTION_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  kfn_req_if.sink   req_in,
  kfn_res_if.source res_out,
  kfn_cfg_if.sink   cfg
);
  import kfn_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int GW = F + 1;          // gain, 0 .. 2^F
  localparam int MW = F + 2;          // multiplier operand, holds gain and 1000
  localparam int AW = DATA_W + 2;     // signed multiplicand
  localparam int PW = AW + MW;        // product
  localparam int NW = DATA_W + 1;     // divider operands

  localparam word_t          ONE_W     = word_t'(64'd1 << F);
  localparam word_t          MN_RESET  = word_t'(((64'd1 << F) + 64'd5) / 64'd10);
  localparam logic [GW-1:0]  ONE_G     = GW'(64'd1 << F);
  localparam logic signed [PW-1:0] FIX_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PW-1:0] FIX_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};

  // shift right by sh with truncation toward zero
  function automatic logic signed [PW-1:0] shr_trunc(input logic signed [PW-1:0] v,
                                                     input int sh);
    logic signed [PW-1:0] bias;
    bias = v[PW-1] ? ((PW'(1) <<< sh) - PW'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

  // saturate to signed 32 bits
  function automatic fix_t clamp32(input logic signed [PW-1:0] v);
    fix_t r;
    if (v > FIX_MAX) begin
      r = fix_t'(FIX_MAX);
    end else if (v < FIX_MIN) begin
      r = fix_t'(FIX_MIN);
    end else begin
      r = fix_t'(v);
    end
    return r;
  endfunction

  // registers
  word_t  pn;
  word_t  mn;
  fix_t   est_mem [NUM_CH];
  word_t  err_mem [NUM_CH];
  state_t state, state_next;
  chan_t  ch;
  fix_t   sample;
  fix_t   est;
  word_t  e;
  logic [NW-1:0]        den;
  logic signed [NW-1:0] diff;
  logic [GW-1:0]        gain;
  fix_t   est_new;
  word_t  err_new;
  fix_t   norm;
  logic   res_valid;
  chan_t  res_channel;
  fix_t   res_filtered;
  fix_t   res_normalized;

  // combinational
  fix_t                 est_cur;
  word_t                err_cur;
  logic [DATA_W:0]      e_sum;
  word_t                e_sat;
  logic [NW-1:0]        den_cur;
  logic signed [NW-1:0] diff_cur;
  logic [GW-1:0]        gain_cur;
  logic signed [PW-1:0] est_sum;
  logic signed [AW-1:0] norm_x;
  logic signed [AW-1:0] norm_off;
  logic [MW-1:0]        norm_k;
  logic signed [PW-1:0] norm_q;
  group_t               grp;
  logic                 accept;
  logic                 res_load;

  logic                 div_start;
  unit_stat_t           div_stat;
  logic [GW-1:0]        div_q;
  logic                 mul_start;
  logic signed [AW-1:0] mul_a;
  logic [MW-1:0]        mul_b;
  unit_stat_t           mul_stat;
  logic signed [PW-1:0] mul_p;

  // no handshake completes while in reset
  assign accept       = req_in.valid && req_in.ready;
  assign req_in.ready = (state == S_IDLE) && !rst;
  assign cfg.ready    = !rst;

  // gain divider
  kfn_serial_div #(
    .NW (NW),
    .QW (GW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NW'(e_sat)),
    .den   (den_cur),
    .stat  (div_stat),
    .q     (div_q)
  );

  // shared multiplier
  kfn_serial_mul #(
    .AW (AW),
    .BW (MW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .p     (mul_p)
  );

  // step arithmetic
  always_comb begin
    est_cur  = est_mem[ch];
    err_cur  = err_mem[ch];
    e_sum    = {1'b0, err_cur} + {1'b0, pn};
    e_sat    = e_sum[DATA_W] ? '1 : e_sum[DATA_W-1:0];
    den_cur  = {1'b0, e_sat} + {1'b0, mn};
    diff_cur = {sample[DATA_W-1], sample} - {est_cur[DATA_W-1], est_cur};
    gain_cur = (den == '0) ? '0 : div_q;
    est_sum  = PW'(est) + shr_trunc(mul_p, F);
    grp      = group_of(ch);
    unique case (grp)
      GRP_TEMP: begin
        norm_off = '0;
        norm_k   = MW'(NORM_K_TEMP);
        norm_q   = shr_trunc(mul_p, F);
      end
      GRP_ACCEL: begin
        norm_off = AW'(ACCEL_OFFSET) <<< F;
        norm_k   = MW'(NORM_K_ACCEL);
        norm_q   = shr_trunc(mul_p, F);
      end
      GRP_GYRO: begin
        norm_off = AW'(GYRO_OFFSET) <<< F;
        norm_k   = MW'(NORM_K_GYRO);
        norm_q   = shr_trunc(mul_p, F);
      end
      GRP_LIGHT: begin
        norm_off = '0;
        norm_k   = MW'(NORM_K_LIGHT);
        norm_q   = shr_trunc(mul_p, F + LIGHT_EXTRA_SHIFT);
      end
      default: begin
        norm_off = '0;
        norm_k   = '0;
        norm_q   = '0;
      end
    endcase
    norm_x = AW'(est_new) + norm_off;
  end

  // sequencer next state and unit starts
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = AW'(diff);
          mul_b      = MW'(gain_cur);
          state_next = S_MUL_EST;
        end
      end
      S_MUL_EST: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = AW'({1'b0, e});
          mul_b      = MW'(ONE_G - gain);
          state_next = S_MUL_ERR;
        end
      end
      S_MUL_ERR: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = norm_x;
          mul_b      = norm_k;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (mul_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || res_out.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pn <= ONE_W;
      mn <= MN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PROCESS_NOISE:     pn <= cfg.data;
        REG_MEASUREMENT_NOISE: mn <= cfg.data;
        default: ;
      endcase
    end
  end

  // per-channel filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        est_mem[i] <= '0;
        err_mem[i] <= ONE_W;
      end
    end else if (res_load) begin
      est_mem[ch] <= est_new;
      err_mem[ch] <= err_new;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch     <= req_in.channel;
      sample <= req_in.sample;
    end
    if (state == S_PREP) begin
      est  <= est_cur;
      e    <= e_sat;
      den  <= den_cur;
      diff <= diff_cur;
    end
    if (state == S_DIV && div_stat.done) begin
      gain <= gain_cur;
    end
    if (state == S_MUL_EST && mul_stat.done) begin
      est_new <= clamp32(est_sum);
    end
    if (state == S_MUL_ERR && mul_stat.done) begin
      err_new <= mul_p[F +: DATA_W];
    end
    if (state == S_NORM && mul_stat.done) begin
      norm <= clamp32(norm_q);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_channel    <= ch;
      res_filtered   <= est_new;
      res_normalized <= norm;
    end
  end

  assign res_out.valid       = res_valid;
  assign res_out.channel_out = res_channel;
  assign res_out.filtered    = res_filtered;
  assign res_out.normalized  = res_normalized;

`ifndef ASSERT_OFF
  // gain never exceeds 1.0
  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_stat.done) |-> (gain_cur <= ONE_G))
    else $error("gain above one");

  // updated error never exceeds the predicted error
  a_err_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_ERR && mul_stat.done) |-> (mul_p[F +: DATA_W] <= e))
    else $error("error covariance grew in update");

  // an accepted request starts the step sequence
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_PREP))
    else $error("accepted request did not start");

  // a new result appears only when a step finishes
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_out.valid) |-> ($past(state) == S_DONE))
    else $error("result without finished step");
`endif

endmodule

@@ rtl/kfn_serial_div.sv @@
// ----------------------------------------------------------------------------
// kfn_serial_div
// Restoring divider, one quotient bit per cycle. Gives floor(num * 2^(QW-1)
// / den) for num <= den, most significant quotient bit first.
// ----------------------------------------------------------------------------
module kfn_serial_div #(
  parameter int NW = 33,
  parameter int QW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [NW-1:0]       den,
  output kfn_pkg::unit_stat_t stat,
  output logic [QW-1:0]       q
);
  import kfn_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [NW:0]   rem;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          first;
  logic          busy;
  logic          done;
  logic [NW:0]   trial;
  logic          ge;

  // first step compares the remainder as is, later steps shift it
  always_comb begin
    trial = first ? rem : {rem[NW-1:0], 1'b0};
    ge    = (trial >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      dvs   <= den;
      q     <= '0;
      first <= 1'b1;
    end else if (busy) begin
      rem   <= ge ? (trial - {1'b0, dvs}) : trial;
      q     <= {q[QW-2:0], ge};
      first <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/kfn_serial_mul.sv @@
// ----------------------------------------------------------------------------
// kfn_serial_mul
// Shift-add multiplier, signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module kfn_serial_mul #(
  parameter int AW = 34,
  parameter int BW = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic        [BW-1:0]     b,
  output kfn_pkg::unit_stat_t      stat,
  output logic signed [AW+BW-1:0]  p
);
  import kfn_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic        [BW-1:0] mplier;
  logic        [CW-1:0] cnt;
  logic                 busy;
  logic                 done;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulate shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PW'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign p         = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ test/multichannel_kalman_normalizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_kalman_normalizer_unit_tb
// Drives sample requests on all eight channels and compares every result
// against an in-bench fixed-point Kalman predictor with its own per-channel
// state. It covers noise register extremes, zero noise and error overflow,
// random and bursty traffic under several idle and stall mixes, and a long
// result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module multichannel_kalman_normalizer_unit_tb;
  import kfn_pkg::*;

  localparam int FRAC        = 16;
  localparam int LATENCY     = 4 * FRAC + 13;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;
  localparam int NORM_SCALE  = 1000;
  localparam int PHASE_ITEMS = 140;

  localparam fix_t  FIX_MAX  = fix_t'(32'h7FFF_FFFF);
  localparam fix_t  FIX_MIN  = fix_t'(32'h8000_0000);
  localparam word_t WORD_MAX = '1;
  localparam word_t ONE_FIX  = word_t'(1) << FRAC;

  typedef struct packed {
    chan_t channel;
    fix_t  filtered;
    fix_t  normalized;
  } kfn_result_t;

  logic clk;
  logic rst;

  kfn_req_if req();
  kfn_res_if res();
  kfn_cfg_if cfg();

  multichannel_kalman_normalizer_unit #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req_in (req),
    .res_out(res),
    .cfg    (cfg)
  );

  // predictor copy of the filter state and noise registers
  fix_t        est_state [NUM_CH];
  word_t       err_state [NUM_CH];
  word_t       proc_noise;
  word_t       meas_noise;
  kfn_result_t predicted_outputs [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > longint'(FIX_MAX)) begin
      return longint'(FIX_MAX);
    end else if (v < longint'(FIX_MIN)) begin
      return longint'(FIX_MIN);
    end
    return v;
  endfunction

  // one filter step on a channel, updates the predictor state
  function automatic kfn_result_t kalman_predict(input chan_t c, input fix_t s);
    longint unsigned one_u, e, denom, gain;
    longint          one_s, cur, nv, offs, divs;
    kfn_result_t     r;
    one_u = 64'd1 << FRAC;
    one_s = longint'(one_u);
    // error plus process noise saturates at the top of 32 bits
    e = {32'd0, err_state[c]} + {32'd0, proc_noise};
    if (e > 64'hFFFF_FFFF) begin
      e = 64'hFFFF_FFFF;
    end
    denom = e + {32'd0, meas_noise};
    gain  = (denom == 0) ? 64'd0 : (e << FRAC) / denom;
    if (gain > one_u) begin
      gain = one_u;
    end
    cur = longint'(est_state[c]);
    nv  = clamp_s32(cur + ((longint'(s) - cur) * longint'(gain)) / one_s);
    est_state[c] = fix_t'(nv);
    err_state[c] = word_t'(((one_u - gain) * e) >> FRAC);
    // group offset and divisor: temp x1, accel /8, gyro /500, light /1024
    if (c == CH_TEMP) begin
      offs = 0;
      divs = 1;
    end else if (c <= CH_ACCEL_LAST) begin
      offs = ACCEL_OFFSET;
      divs = 8;
    end else if (c <= CH_GYRO_LAST) begin
      offs = GYRO_OFFSET;
      divs = 500;
    end else begin
      offs = 0;
      divs = 1024;
    end
    r.channel    = c;
    r.filtered   = fix_t'(nv);
    r.normalized = fix_t'(clamp_s32(((nv + offs * one_s) * NORM_SCALE) / (divs * one_s)));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("mismatch %s: expected %0d got %0d (cycle %0d)", what, want, got, cycle_count);
    end
  endtask

  // result check, register write tracking and request prediction
  always @(posedge clk) begin : monitor
    kfn_result_t got;
    kfn_result_t want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got = '{res.channel_out, res.filtered, res.normalized};
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result with nothing pending, channel", -1, got.channel);
        end else begin
          want = predicted_outputs.pop_front();
          if (got.channel !== want.channel) begin
            report_mismatch("channel_out", want.channel, got.channel);
          end
          if (got.filtered !== want.filtered) begin
            report_mismatch("filtered", want.filtered, got.filtered);
          end
          if (got.normalized !== want.normalized) begin
            report_mismatch("normalized", want.normalized, got.normalized);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PROCESS_NOISE:     proc_noise = cfg.data;
          REG_MEASUREMENT_NOISE: meas_noise = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        predicted_outputs.push_back(kalman_predict(req.channel, req.sample));
      end
    end
  end

  // result ready: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res.ready = 1'b0;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      res.ready = 1'b0;
    end else begin
      res.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multichannel_kalman_normalizer_unit verification failed");
      $finish;
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_sample(input chan_t c, input fix_t s);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid   = 1'b1;
    req.channel = c;
    req.sample  = s;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t d);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // stop offering and wait for every pending result
  task automatic wait_idle();
    @(negedge clk);
    req.valid = 1'b0;
    while (predicted_outputs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic word_t pick_noise();
    case ($urandom_range(7))
      0:       return '0;
      1:       return word_t'(1);
      2:       return WORD_MAX;
      3:       return word_t'($urandom);
      default: return word_t'($urandom_range(1 << 18));
    endcase
  endfunction

  function automatic fix_t pick_extreme();
    case ($urandom_range(3))
      0:       return FIX_MAX;
      1:       return FIX_MIN;
      2:       return '0;
      default: return fix_t'(-1);
    endcase
  endfunction

  // mostly noisy runs around a level on one channel, plus raw and extreme values
  task automatic send_random_items(input int count);
    int    sent;
    int    run;
    int    k;
    int    mode;
    chan_t c;
    fix_t  level;
    sent = 0;
    while (sent < count) begin
      c    = chan_t'($urandom_range(NUM_CH - 1));
      mode = $urandom_range(99);
      if (mode < 70) begin
        level = fix_t'(int'($urandom_range(1 << 24)) - (1 << 23));
        run   = $urandom_range(3, 10);
        for (k = 0; k < run; k++) begin
          send_sample(c, level + fix_t'(int'($urandom_range(1 << 16)) - (1 << 15)));
          sent++;
        end
      end else if (mode < 85) begin
        send_sample(c, fix_t'($urandom));
        sent++;
      end else begin
        send_sample(c, pick_extreme());
        sent++;
      end
    end
  endtask

  // default noise, every channel at the sample extremes
  task automatic test_reset_defaults();
    int k;
    for (k = 0; k < NUM_CH; k++) begin
      send_sample(chan_t'(k), k[0] ? FIX_MIN : FIX_MAX);
    end
    send_sample(CH_TEMP, fix_t'(1));
    send_sample(chan_t'(4), fix_t'(-1));
    wait_idle();
  endtask

  // zero noise gives full gain, then a zero denominator keeps the estimate
  task automatic test_zero_noise();
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    send_sample(chan_t'(2), fix_t'(ONE_FIX));
    send_sample(chan_t'(2), fix_t'(ONE_FIX));
    send_sample(chan_t'(2), FIX_MIN);
    wait_idle();
  endtask

  // saturating error sum with the largest measurement noise, then a measurement noise of one
  task automatic test_noise_extremes();
    write_reg(REG_PROCESS_NOISE, WORD_MAX);
    write_reg(REG_MEASUREMENT_NOISE, WORD_MAX);
    send_sample(chan_t'(7), FIX_MAX);
    send_sample(CH_TEMP, FIX_MIN);
    wait_idle();
    write_reg(REG_MEASUREMENT_NOISE, word_t'(1));
    send_sample(chan_t'(5), FIX_MAX);
    send_sample(chan_t'(3), FIX_MIN);
    wait_idle();
  endtask

  // writes to unused indexes must leave the noise registers alone
  task automatic test_unused_index();
    int k;
    write_reg(REG_PROCESS_NOISE, ONE_FIX);
    write_reg(REG_MEASUREMENT_NOISE, word_t'($urandom_range(1 << 14)));
    for (k = 0; k < 3; k++) begin
      write_reg(cfg_idx_t'($urandom_range(REG_MEASUREMENT_NOISE + 1, (1 << CFG_IDX_W) - 1)),
                word_t'($urandom));
    end
    for (k = 0; k < 4; k++) begin
      send_sample(chan_t'($urandom_range(NUM_CH - 1)), fix_t'($urandom));
    end
    wait_idle();
  endtask

  // random traffic in two noise settings under one idle/stall mix
  task automatic test_random_phase(input int idle, input int stall, input int count);
    int half;
    idle_pct  = idle;
    stall_pct = stall;
    for (half = 0; half < 2; half++) begin
      write_reg(REG_PROCESS_NOISE, pick_noise());
      write_reg(REG_MEASUREMENT_NOISE, pick_noise());
      send_random_items(count / 2);
      wait_idle();
    end
  endtask

  // long result hold-off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    holds_asked++;
    for (k = 0; k < 24; k++) begin
      send_sample(chan_t'($urandom_range(NUM_CH - 1)), fix_t'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    int k;
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.channel = '0;
    req.sample  = '0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    proc_noise  = ONE_FIX;
    meas_noise  = (ONE_FIX + 5) / 10;
    for (k = 0; k < NUM_CH; k++) begin
      est_state[k] = '0;
      err_state[k] = ONE_FIX;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_zero_noise();
    test_noise_extremes();
    test_unused_index();
    test_random_phase(0, 0, PHASE_ITEMS);
    test_random_phase(73, 0, PHASE_ITEMS);
    test_random_phase(0, 73, PHASE_ITEMS);
    test_random_phase(11, 11, PHASE_ITEMS);
    test_backpressure();

    // let anything stray show up before the verdict
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multichannel_kalman_normalizer_unit verification clean");
    end else begin
      $display("multichannel_kalman_normalizer_unit verification failed");
    end
    $finish;
  end

endmodule
